// ===== rtl/core/rpb_pkg.sv =====
`default_nettype none

package rpb_pkg;

    // Field widths fixed by the word formats.
    localparam int RAND_W  = 12;
    localparam int CNT_W   = 6;
    localparam int SLOT_W  = 5;
    localparam int ENTRY_W = 8;
    localparam int STEP_W  = $clog2(RAND_W);

    localparam logic [ENTRY_W-1:0] EMPTY_MARK = 8'hFF;
    localparam logic [CNT_W-1:0]   TRACK_RESET = 6'd32;

    // Item kinds.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [RAND_W-1:0] random_value;
        logic [SLOT_W-1:0] slot_index;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_written;
        logic [ENTRY_W-1:0] entry_value;
        logic               permutation_done;
        logic               draw_error;
    } result_t;

    // Commands from the sequencer to the slot table.
    typedef struct packed {
        logic clear;
        logic wr_en;
        logic rd_en;
    } tbl_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DIV,
        ST_FIND,
        ST_READ,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpb_table.sv =====
`default_nettype none

module rpb_table
    import rpb_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tbl_ctl_t                       ctl,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  wire logic [ENTRY_W-1:0]             wr_data,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output logic      [ENTRY_W-1:0]             rd_data,
    output logic                                rd_filled,
    output logic      [TABLE_DEPTH-1:0]         filled
);

    logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] filled_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_filled_reg;
    logic [TABLE_DEPTH-1:0] filled_next;

    // A slot counts as empty until written; a clear drops every filled bit at once.
    always_comb
    begin
        filled_next = filled_reg;
        if (ctl.clear)
        begin
            filled_next = '0;
        end
        else if (ctl.wr_en)
        begin
            filled_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
        end
    end

    // Entry storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg   <= mem[rd_addr];
            rd_filled_reg <= filled_reg[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign rd_filled = rd_filled_reg;
    assign filled    = filled_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rpb_mod.sv =====
`default_nettype none

module rpb_mod
    import rpb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAND_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]  divisor,
    output logic                   done,
    output logic [CNT_W-1:0]       remainder
);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [RAND_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]   dvs_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic [CNT_W-1:0]   rem_next;
    logic               last_step;

    // One restoring step per cycle: bring down the next dividend bit.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[RAND_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = diff[CNT_W-1:0];
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    assign last_step = (step_reg == STEP_W'(RAND_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && last_step)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            step_reg <= '0;
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            dvd_reg  <= {dvd_reg[RAND_W-2:0], 1'b0};
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    // The divisor is a count of empty slots and is never zero.
    property p_divisor_nonzero;
        @(posedge clk) disable iff (!rst_n)
        start |-> (divisor != '0);
    endproperty
    a_divisor_nonzero: assert property (p_divisor_nonzero)
        else $error("remainder unit started with a zero divisor");

    // The remainder always stays below the divisor.
    property p_rem_bound;
        @(posedge clk) disable iff (!rst_n)
        done |-> (rem_reg < dvs_reg);
    endproperty
    a_rem_bound: assert property (p_rem_bound)
        else $error("remainder not below divisor");

    // A new start never lands while a division is running.
    property p_no_restart;
        @(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start;
    endproperty
    a_no_restart: assert property (p_no_restart)
        else $error("remainder unit restarted while busy");

endmodule

`default_nettype wire

// ===== rtl/core/random_permutation_builder.sv =====
`default_nettype none

// Channel   Valid         Stall          Word      Direction
// item      item_valid    item_stall     item      in  (clear, draw, read)
// result    result_valid  result_stall   result    out (one per item)
// config    track_count_we  -            track_count_wdata (6 bits)
//
// A clear or an unused kind goes straight to the emit state; a read passes through
// the read state for the registered table read. A draw makes one pass over the
// filled bits of the n = min(track_count, TABLE_DEPTH) active slots to count the empty
// ones, runs the bit-serial remainder unit, then a second pass finds the chosen slot.
// Reset empties every slot at once through its filled bit; track_count returns to 32.
// A new item is taken whenever the sequencer is idle, even with a result still held.
// A stalled result holds the sequencer in its emit state until the output register frees.

module random_permutation_builder
    import rpb_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire item_t            item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result,
    input  wire logic             track_count_we,
    input  wire logic [CNT_W-1:0] track_count_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       track_reg;
    logic [CNT_W-1:0]       placed_reg, placed_next;
    logic [RAND_W-1:0]      rnd_reg, rnd_next;
    logic [SLOT_W-1:0]      sidx_reg, sidx_next;
    logic [TABLE_DEPTH-1:0] snap_reg, snap_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic [CNT_W-1:0]       empties_reg, empties_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    result_t                pend_reg, pend_next;
    result_t                res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;

    logic [CNT_W-1:0]       n_active;
    logic                   sidx_in_range;
    tbl_ctl_t               tbl_ctl;
    logic [AW-1:0]          tbl_rd_addr;
    logic [ENTRY_W-1:0]     tbl_rd_data;
    logic                   tbl_rd_filled;
    logic [TABLE_DEPTH-1:0] tbl_filled;
    logic                   mod_start;
    logic                   mod_done;
    logic [CNT_W-1:0]       mod_rem;
    logic                   out_take;

    // Number of slots taking part, saturated at the table depth.
    assign n_active = (32'(track_reg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : track_reg;

    assign sidx_in_range = (32'(sidx_reg) < 32'(TABLE_DEPTH));
    assign tbl_rd_addr   = AW'(item.slot_index);
    assign out_take      = res_valid_reg && !result_stall;

    rpb_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tbl_ctl),
        .wr_addr   (AW'(scan_reg)),
        .wr_data   ({2'b00, placed_reg}),
        .rd_addr   (tbl_rd_addr),
        .rd_data   (tbl_rd_data),
        .rd_filled (tbl_rd_filled),
        .filled    (tbl_filled)
    );

    rpb_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (rnd_reg),
        .divisor   (empties_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Sequencer: next state, table commands and the pending result word.
    always_comb
    begin
        state_next     = state_reg;
        placed_next    = placed_reg;
        rnd_next       = rnd_reg;
        sidx_next      = sidx_reg;
        snap_next      = snap_reg;
        scan_next      = scan_reg;
        empties_next   = empties_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !out_take;
        tbl_ctl        = '0;
        mod_start      = 1'b0;
        item_stall     = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    rnd_next  = item.random_value;
                    sidx_next = item.slot_index;
                    pend_next = '{slot_written: '0, entry_value: EMPTY_MARK,
                                  permutation_done: 1'b0, draw_error: 1'b0};
                    case (item.kind)
                        KIND_CLEAR:
                        begin
                            tbl_ctl.clear = 1'b1;
                            placed_next   = '0;
                            state_next    = ST_EMIT;
                        end
                        KIND_DRAW:
                        begin
                            snap_next    = tbl_filled;
                            scan_next    = '0;
                            empties_next = '0;
                            state_next   = ST_COUNT;
                        end
                        KIND_READ:
                        begin
                            tbl_ctl.rd_en = 1'b1;
                            state_next    = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            // First pass: count the empty slots among the active ones.
            ST_COUNT:
            begin
                if (scan_reg == n_active)
                begin
                    if (empties_reg == '0)
                    begin
                        pend_next.draw_error = 1'b1;
                        state_next           = ST_EMIT;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    if (!snap_reg[0])
                    begin
                        empties_next = empties_reg + CNT_W'(1);
                    end
                    snap_next = snap_reg >> 1;
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            // Wait for the random word reduced modulo the empty count.
            ST_DIV:
            begin
                if (mod_done)
                begin
                    k_next     = mod_rem;
                    snap_next  = tbl_filled;
                    scan_next  = '0;
                    state_next = ST_FIND;
                end
            end

            // Second pass: stop on the k-th empty slot and fill it.
            ST_FIND:
            begin
                if (!snap_reg[0] && (k_reg == '0))
                begin
                    tbl_ctl.wr_en = 1'b1;
                    placed_next   = placed_reg + CNT_W'(1);
                    pend_next     = '{slot_written: SLOT_W'(scan_reg),
                                      entry_value: {2'b00, placed_reg},
                                      permutation_done: (empties_reg == CNT_W'(1)),
                                      draw_error: 1'b0};
                    state_next    = ST_EMIT;
                end
                else
                begin
                    if (!snap_reg[0])
                    begin
                        k_next = k_reg - CNT_W'(1);
                    end
                    snap_next = snap_reg >> 1;
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            // Table read data arrives in the cycle after the request, from the registered read port.
            ST_READ:
            begin
                pend_next.slot_written = sidx_reg;
                if (sidx_in_range && tbl_rd_filled)
                begin
                    pend_next.entry_value = tbl_rd_data;
                end
                state_next = ST_EMIT;
            end

            // Hand the word to the output register once it is free.
            ST_EMIT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            placed_reg    <= '0;
            track_reg     <= TRACK_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            placed_reg    <= placed_next;
            res_valid_reg <= res_valid_next;
            if (track_count_we)
            begin
                track_reg <= track_count_wdata;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        rnd_reg     <= rnd_next;
        sidx_reg    <= sidx_next;
        snap_reg    <= snap_next;
        scan_reg    <= scan_next;
        empties_reg <= empties_next;
        k_reg       <= k_next;
        pend_reg    <= pend_next;
        res_reg     <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // The locate pass never runs past the active slots.
    property p_find_bound;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND) |-> (scan_reg < n_active);
    endproperty
    a_find_bound: assert property (p_find_bound)
        else $error("slot search ran past the active slots");

    // A division is only under way with at least one empty slot.
    property p_div_nonzero;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (empties_reg != '0);
    endproperty
    a_div_nonzero: assert property (p_div_nonzero)
        else $error("division entered with no empty slot");

    // The remainder unit reports only while the sequencer waits for it.
    property p_mod_done_state;
        @(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_DIV);
    endproperty
    a_mod_done_state: assert property (p_mod_done_state)
        else $error("remainder result outside the division wait");

    // A table write always lands on a slot that was empty.
    property p_write_empty;
        @(posedge clk) disable iff (!rst_n)
        tbl_ctl.wr_en |-> !snap_reg[0];
    endproperty
    a_write_empty: assert property (p_write_empty)
        else $error("draw wrote a filled slot");

endmodule

`default_nettype wire

// ===== tb/tb_random_permutation_builder.sv =====
`default_nettype none

module tb_random_permutation_builder
    import rpb_pkg::*;
();

    localparam int TABLE_SLOTS = 32;
    localparam int ITEM_TARGET = 1300;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD = 600;
    localparam int REPORT_MAX = 10;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Tracks the slot table, the placement position and the track count, and keeps the
    // result words still owed by the block in arrival order.
    class permutation_checker;
        logic [ENTRY_W-1:0] slot_entry[TABLE_SLOTS];
        logic [CNT_W-1:0] placed;
        logic [CNT_W-1:0] track;
        result_t pending_results[$];
        int unsigned failures;

        function new();
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                slot_entry[i] = EMPTY_MARK;
            end
            placed = '0;
            track = TRACK_RESET;
            failures = 0;
        endfunction

        function void set_track(logic [CNT_W-1:0] value);
            track = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Works out the result word for an accepted input word and moves the table on.
        function void note_item(item_t it);
            result_t r;
            int unsigned span;
            int unsigned empties;
            int unsigned k;
            int unsigned pick;
            r.slot_written = '0;
            r.entry_value = EMPTY_MARK;
            r.permutation_done = 1'b0;
            r.draw_error = 1'b0;
            if (it.kind == KIND_CLEAR)
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    slot_entry[i] = EMPTY_MARK;
                end
                placed = '0;
            end
            else if (it.kind == KIND_DRAW)
            begin
                // Only the first track_count slots take part, saturated at the table depth.
                span = (track > TABLE_SLOTS) ? TABLE_SLOTS : track;
                empties = 0;
                for (int i = 0; i < span; i++)
                begin
                    if (slot_entry[i] == EMPTY_MARK)
                    begin
                        empties++;
                    end
                end
                if (empties == 0)
                begin
                    r.draw_error = 1'b1;
                end
                else
                begin
                    // Pick the k-th empty slot in slot order, counting from zero.
                    k = it.random_value % empties;
                    pick = 0;
                    for (int i = 0; i < span; i++)
                    begin
                        if (slot_entry[i] == EMPTY_MARK)
                        begin
                            if (k == 0)
                            begin
                                pick = i;
                                break;
                            end
                            k--;
                        end
                    end
                    r.slot_written = SLOT_W'(pick);
                    r.entry_value = ENTRY_W'(placed);
                    r.permutation_done = (empties == 1);
                    slot_entry[pick] = ENTRY_W'(placed);
                    placed = placed + 1'b1;
                end
            end
            else if (it.kind == KIND_READ)
            begin
                r.slot_written = it.slot_index;
                r.entry_value = slot_entry[it.slot_index];
            end
            pending_results.push_back(r);
        endfunction

        // Compares a result word from the block with the oldest one owed.
        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                begin
                    $display("unexpected result word: slot %0d entry %0d done %0b error %0b",
                             got.slot_written, got.entry_value, got.permutation_done,
                             got.draw_error);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got.slot_written !== want.slot_written || got.entry_value !== want.entry_value
                || got.permutation_done !== want.permutation_done
                || got.draw_error !== want.draw_error)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                begin
                    $display("result mismatch at %0t: expected slot %0d entry %0d done %0b error %0b",
                             $time, want.slot_written, want.entry_value,
                             want.permutation_done, want.draw_error);
                    $display("                        got slot %0d entry %0d done %0b error %0b",
                             got.slot_written, got.entry_value, got.permutation_done,
                             got.draw_error);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic track_count_we = 1'b0;
    logic [CNT_W-1:0] track_count_wdata = '0;

    permutation_checker tracker;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    bit tx_busy = 1'b1;
    bit rx_busy = 1'b1;
    bit hold_request = 1'b0;

    random_permutation_builder #(
        .TABLE_DEPTH(TABLE_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .track_count_we(track_count_we),
        .track_count_wdata(track_count_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is ended if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_random_permutation_builder: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic item_t make_item(logic [1:0] kind, logic [RAND_W-1:0] rnd,
                                        logic [SLOT_W-1:0] idx);
        item_t it;
        it.kind = kind;
        it.random_value = rnd;
        it.slot_index = idx;
        return it;
    endfunction

    // Random fields for the random phases.
    function automatic item_t random_item(logic [1:0] kind);
        return make_item(kind, RAND_W'($urandom_range(0, 4095)),
                         SLOT_W'($urandom_range(0, 31)));
    endfunction

    // Offers one input word after a random gap and waits until the block takes it.
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = tx_busy ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        tracker.note_item(it);
        items_sent++;
    endtask

    // Stops offering words until every owed result word has come back.
    task automatic drain();
        item_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_track_count(input logic [CNT_W-1:0] value);
        track_count_wdata <= value;
        track_count_we <= 1'b1;
        @(posedge clk);
        track_count_we <= 1'b0;
        tracker.set_track(value);
    endtask

    // Result side: random stall before each word, with one long hold on request.
    initial
    begin
        int unsigned gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = rx_busy ? $urandom_range(0, 15) : 0;
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
            begin
                @(posedge clk);
            end
            tracker.check_result(result);
            if ($urandom_range(0, 39) == 0)
            begin
                rx_busy = !rx_busy;
            end
        end
    end

    // Stimulus: directed words first, then phases of random permutation runs.
    initial
    begin
        logic [CNT_W-1:0] tc;
        int unsigned span;
        int unsigned draws;
        int unsigned phase;
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table after reset, the unused kind, the extremes of the random word.
        send_item(make_item(KIND_READ, 12'h000, 5'd0));
        send_item(make_item(KIND_READ, 12'hFFF, 5'd31));
        send_item(make_item(KIND_UNUSED, 12'hFFF, 5'd31));
        send_item(make_item(KIND_DRAW, 12'h000, 5'd0));
        send_item(make_item(KIND_DRAW, 12'hFFF, 5'd31));
        send_item(make_item(KIND_READ, 12'h000, 5'd0));
        send_item(make_item(KIND_CLEAR, 12'hFFF, 5'd31));
        send_item(make_item(KIND_READ, 12'h000, 5'd0));
        drain();

        // One slot: the first draw completes the permutation, the next one fails.
        write_track_count(6'd1);
        send_item(make_item(KIND_DRAW, 12'hFFF, 5'd0));
        send_item(make_item(KIND_DRAW, 12'h123, 5'd0));
        send_item(make_item(KIND_READ, 12'h000, 5'd0));
        send_item(make_item(KIND_READ, 12'h000, 5'd1));
        drain();

        // No slots at all: every draw fails.
        write_track_count(6'd0);
        send_item(make_item(KIND_DRAW, 12'h800, 5'd16));
        drain();

        // Count above the table depth is saturated.
        write_track_count(6'd63);
        send_item(make_item(KIND_CLEAR, 12'h000, 5'd0));
        send_item(make_item(KIND_DRAW, 12'hFFF, 5'd0));
        send_item(make_item(KIND_DRAW, 12'h555, 5'd0));
        send_item(make_item(KIND_READ, 12'h000, 5'd21));
        send_item(make_item(KIND_UNUSED, 12'hAAA, 5'd10));
        drain();

        // Two slots run to completion and one draw beyond.
        write_track_count(6'd2);
        send_item(make_item(KIND_CLEAR, 12'h000, 5'd0));
        send_item(make_item(KIND_DRAW, 12'hAAA, 5'd0));
        send_item(make_item(KIND_DRAW, 12'h555, 5'd0));
        send_item(make_item(KIND_DRAW, 12'hFFF, 5'd0));
        drain();

        // Random phases. A phase without a clear continues the table of the one before,
        // so a changed count takes effect in the middle of a permutation.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: tc = 6'd1;
                1: tc = 6'd32;
                2: tc = 6'd63;
                3: tc = CNT_W'($urandom_range(33, 63));
                4: tc = 6'd0;
                5: tc = 6'd2;
                default: tc = CNT_W'($urandom_range(1, 32));
            endcase
            tx_busy = ($urandom_range(0, 2) != 0);
            if (phase == 2)
            begin
                // The result side holds off while words keep coming, so the block backs up.
                tc = 6'd32;
                tx_busy = 1'b0;
                hold_request = 1'b1;
            end
            write_track_count(tc);
            span = (tc > TABLE_SLOTS) ? TABLE_SLOTS : tc;
            if ($urandom_range(0, 3) != 0)
            begin
                send_item(random_item(KIND_CLEAR));
            end
            draws = span + $urandom_range(0, 2);
            if ($urandom_range(0, 5) == 0)
            begin
                draws = draws / 2;
            end
            for (int i = 0; i < draws; i++)
            begin
                send_item(random_item(KIND_DRAW));
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(random_item(KIND_READ));
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    send_item(random_item(KIND_UNUSED));
                end
                if ($urandom_range(0, 59) == 0)
                begin
                    send_item(random_item(KIND_CLEAR));
                end
            end
            repeat ($urandom_range(1, 4))
            begin
                send_item(random_item(KIND_READ));
            end
            drain();
            phase++;
        end

        // Let any stray result word show up before the verdict.
        repeat (100) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
        begin
            $display("tb_random_permutation_builder: PASS");
        end
        else
        begin
            $display("tb_random_permutation_builder: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
